// File: rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// File: rtl/ssrq_pkg.sv
// ----------------------------------------------------------------------------
// ssrq_pkg
// Types and constants for the sorted radius query block.
// ----------------------------------------------------------------------------
package ssrq_pkg;
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] REG_NX = 2'd0;
  localparam logic [1:0] REG_NY = 2'd1;
  localparam logic [1:0] REG_NZ = 2'd2;
  localparam logic [1:0] REG_RAD = 2'd3;

  localparam int PW = 48;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PROJ, ST_SUM, ST_LOAD, ST_QSCAN, ST_QEMIT
  } state_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic signed [PW-1:0] p;
    logic [5:0] idx;
  } slot_t;

  // broadcast from control to the cells
  typedef struct packed {
    logic ins;
    logic shift;
    logic signed [PW-1:0] lo;
    logic signed [PW-1:0] hi;
    logic [48:0] r2;
  } cell_ctl_t;
endpackage

// File: rtl/ssrq_if.sv
// ----------------------------------------------------------------------------
// ssrq_in_if / ssrq_out_if / ssrq_cfg_if
// Valid/ready channels of the block.
// ----------------------------------------------------------------------------
interface ssrq_in_if;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  modport source (output valid, cmd, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, pos_z, output ready);
endinterface

interface ssrq_out_if;
  logic valid;
  logic ready;
  logic [5:0] match_index;
  logic found;
  logic last;
  modport source (output valid, match_index, found, last, input ready);
  modport sink (input valid, match_index, found, last, output ready);
endinterface

interface ssrq_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/ssrq_cell.sv
// ----------------------------------------------------------------------------
// ssrq_cell
// One slot of the sorted chain: insert/shift on load, range and distance
// test on query.
// ----------------------------------------------------------------------------
module ssrq_cell (
  input  logic clk,
  input  ssrq_pkg::cell_ctl_t ctl,
  input  ssrq_pkg::slot_t new_slot,
  input  ssrq_pkg::slot_t prev_slot,
  input  logic prev_gt,
  input  logic occ,
  output ssrq_pkg::slot_t slot,
  output logic gt,
  output logic hit
);
  import ssrq_pkg::*;
  logic signed [24:0] dx, dy, dz;
  logic [49:0] sx, sy, sz;
  logic [51:0] d2;
  logic inr;
  logic hit_r;

  // gt: stored projection is above the new one (new item goes before)
  assign gt = occ && (slot.p > new_slot.p);

  always_ff @(posedge clk) begin
    if ((ctl.shift && gt) || (ctl.ins && !occ)) begin
      slot <= prev_gt ? prev_slot : new_slot;
    end
  end

  assign dx = 25'(slot.x) - 25'(new_slot.x);
  assign dy = 25'(slot.y) - 25'(new_slot.y);
  assign dz = 25'(slot.z) - 25'(new_slot.z);
  assign inr = (slot.p >= ctl.lo) && (slot.p < ctl.hi);

  always_ff @(posedge clk) begin
    sx <= 50'(dx) * 50'(dx);
    sy <= 50'(dy) * 50'(dy);
    sz <= 50'(dz) * 50'(dz);
    hit_r <= occ && inr;
  end

  assign d2 = 52'(sx) + 52'(sy) + 52'(sz);
  assign hit = hit_r && (d2 < 52'(ctl.r2));
endmodule

// File: rtl/spatial_sort_radius_query_top.sv
// Load: each item passes through project, sum and insert; clear, unused code
// and a load into a full store are handled in idle. Query: after project and
// sum the scan tests one slot per cycle while the output is free; the block
// takes no new item until the current one is done.
// Reset (synchronous, rst high) empties the store and restores the register
// defaults; slot contents are not cleared.
// ----------------------------------------------------------------------------
// spatial_sort_radius_query_top
// Sorted store of positions with radius query over a chain of cells.
// ----------------------------------------------------------------------------
module spatial_sort_radius_query_top #(
  parameter int CAPACITY = 64
) (
  input logic clk,
  input logic rst,
  ssrq_in_if.sink in_ch,
  ssrq_out_if.source out_ch,
  ssrq_cfg_if.sink cfg
);
  import ssrq_pkg::*;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  state_t state, state_next;
  logic signed [15:0] nx, ny, nz;
  logic [23:0] rad;
  logic [CW-1:0] count;
  logic [1:0] cmd;
  logic signed [23:0] px, py, pz;
  logic signed [39:0] mx, my, mz;
  slot_t new_slot;
  cell_ctl_t ctl;
  slot_t slots [CAPACITY];
  logic [CAPACITY-1:0] gts, hits, occs;
  logic [CW-1:0] scan;
  logic any;
  logic [5:0] oidx;
  logic ofound, olast, ovalid;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      nx <= 16'sd25782; ny <= 16'sd10383; nz <= 16'sd17353; rad <= 24'd1;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_NX: nx <= cfg.data[15:0];
        REG_NY: ny <= cfg.data[15:0];
        REG_NZ: nz <= cfg.data[15:0];
        REG_RAD: rad <= cfg.data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd <= in_ch.cmd; px <= in_ch.pos_x; py <= in_ch.pos_y; pz <= in_ch.pos_z;
    end
    mx <= px * nx; my <= py * ny; mz <= pz * nz;
    if (state == ST_SUM) begin
      new_slot.x <= px; new_slot.y <= py; new_slot.z <= pz;
      new_slot.p <= PW'(mx) + PW'(my) + PW'(mz);
      new_slot.idx <= 6'(count);
    end
  end

  always_comb begin
    ctl.ins = (state == ST_LOAD);
    ctl.shift = (state == ST_LOAD);
    ctl.lo = new_slot.p - (PW'(rad) <<< 15);
    ctl.hi = new_slot.p + (PW'(rad) <<< 15);
    ctl.r2 = 49'(rad) * 49'(rad);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occs[i] = (CW'(i) < count);
    ssrq_cell u_cell (
      .clk(clk), .ctl(ctl), .new_slot(new_slot),
      .prev_slot(i == 0 ? new_slot : slots[(i == 0) ? 0 : i - 1]),
      .prev_gt(i == 0 ? 1'b0 : gts[(i == 0) ? 0 : i - 1]),
      .occ(occs[i]), .slot(slots[i]), .gt(gts[i]), .hit(hits[i])
    );
  end

  logic [5:0] idxs [CAPACITY];
  for (genvar i = 0; i < CAPACITY; i++) begin : g_idx
    assign idxs[i] = slots[i].idx;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_ch.valid) begin
        if (in_ch.cmd == CMD_QUERY ||
            (in_ch.cmd == CMD_LOAD && count != CW'(CAPACITY)))
          state_next = ST_PROJ;
      end
      ST_PROJ: state_next = ST_SUM;
      ST_SUM: state_next = (cmd == CMD_LOAD) ? ST_LOAD : ST_QSCAN;
      ST_LOAD: state_next = ST_IDLE;
      ST_QSCAN: state_next = ST_QEMIT;
      ST_QEMIT: if (scan == count && any && !ovalid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; count <= '0; ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_CLEAR) count <= '0;
      if (state == ST_LOAD) count <= count + 1'b1;
      if (state == ST_QSCAN) begin
        scan <= '0; any <= 1'b0;
      end else if (state == ST_QEMIT && (!ovalid || out_ch.ready) && scan != count) begin
        scan <= scan + 1'b1;
        if (hits[scan[IW-1:0]]) begin
          // last flag is settled by looking ahead for remaining hits
          ovalid <= 1'b1; ofound <= 1'b1; oidx <= idxs[scan[IW-1:0]];
          olast <= ((hits >> scan) >> 1) == '0;
          any <= 1'b1;
        end else if (scan + 1'b1 == count && !any) begin
          ovalid <= 1'b1; ofound <= 1'b0; oidx <= '0; olast <= 1'b1; any <= 1'b1;
        end else begin
          ovalid <= 1'b0;
        end
      end else if (state == ST_QEMIT && count == '0 && !any && !ovalid) begin
        ovalid <= 1'b1; ofound <= 1'b0; oidx <= '0; olast <= 1'b1; any <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  assign out_ch.valid = ovalid;
  assign out_ch.match_index = oidx;
  assign out_ch.found = ofound;
  assign out_ch.last = olast;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_cnt, clk, rst, 1'b1, count <= CW'(CAPACITY))
  `ASSERT_IMPL(a_rdy, clk, rst, in_ch.ready, !ovalid)
  `ASSERT_NEXT(a_ld, clk, rst, state == ST_LOAD, count == $past(count) + 1'b1)
endmodule

// File: tb/spatial_sort_radius_query_top_tb.sv
// ----------------------------------------------------------------------------
// spatial_sort_radius_query_top_tb
// Drives load, query, clear and unused-code items into the sorted radius
// query block under several normal and radius settings and random idling on
// both sides. An in-bench sorted store predicts every result; each one is
// checked field by field, in order.
// ----------------------------------------------------------------------------
module spatial_sort_radius_query_top_tb;
  import ssrq_pkg::*;

  localparam int SLOTS = 64;
  localparam int MAX_CYCLES = 1000000;

  typedef struct packed {
    logic [1:0] cmd;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } cmd_item_t;

  typedef struct packed {
    logic [5:0] idx;
    logic found;
    logic last;
  } match_t;

  logic clk;
  logic rst;

  ssrq_in_if in_ch();
  ssrq_out_if out_ch();
  ssrq_cfg_if cfg();

  spatial_sort_radius_query_top #(.CAPACITY(SLOTS)) uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg)
  );

  cmd_item_t pending_items[$];
  match_t expected_matches[$];

  logic signed [15:0] nrm_x, nrm_y, nrm_z;
  logic [23:0] radius;
  int n_stored;
  logic [5:0] st_idx[SLOTS];
  longint st_x[SLOTS];
  longint st_y[SLOTS];
  longint st_z[SLOTS];
  longint st_p[SLOTS];

  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int cycles;

  always #4 clk = ~clk;

  function automatic void add_item(cmd_item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic void add_match(match_t m);
    expected_matches = {expected_matches, m};
  endfunction

  function automatic longint project(longint x, longint y, longint z);
    return x * longint'(nrm_x) + y * longint'(nrm_y) + z * longint'(nrm_z);
  endfunction

  // sorted store update; queries add the expected matches
  function automatic void predict_item(cmd_item_t it);
    longint p, lo, hi, rr, r2, dx, dy, dz, dist2;
    int pos;
    int n;
    n = 0;
    case (it.cmd)
      CMD_CLEAR: begin
        n_stored = 0;
      end
      CMD_LOAD: begin
        if (n_stored < SLOTS) begin
          p = project(it.x, it.y, it.z);
          pos = 0;
          while (pos < n_stored && st_p[pos] <= p) pos++;
          for (int i = n_stored; i > pos; i--) begin
            st_idx[i] = st_idx[i-1];
            st_x[i] = st_x[i-1];
            st_y[i] = st_y[i-1];
            st_z[i] = st_z[i-1];
            st_p[i] = st_p[i-1];
          end
          st_idx[pos] = 6'(n_stored);
          st_x[pos] = it.x;
          st_y[pos] = it.y;
          st_z[pos] = it.z;
          st_p[pos] = p;
          n_stored++;
        end
      end
      CMD_QUERY: begin
        p = project(it.x, it.y, it.z);
        rr = longint'(radius) <<< 15;
        lo = p - rr;
        hi = p + rr;
        r2 = longint'(radius) * longint'(radius);
        for (int i = 0; i < n_stored; i++) begin
          if (st_p[i] >= lo && st_p[i] < hi) begin
            dx = st_x[i] - it.x;
            dy = st_y[i] - it.y;
            dz = st_z[i] - it.z;
            dist2 = dx * dx + dy * dy + dz * dz;
            if (dist2 < r2) begin
              add_match('{st_idx[i], 1'b1, 1'b0});
              n++;
            end
          end
        end
        if (n == 0) add_match('{6'd0, 1'b0, 1'b1});
        else expected_matches[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cmd_item_t it;
        it = pending_items.pop_front();
        in_ch.cmd <= it.cmd;
        in_ch.pos_x <= it.x;
        in_ch.pos_y <= it.y;
        in_ch.pos_z <= it.z;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (in_ch.valid && in_ch.ready)
        predict_item('{in_ch.cmd, in_ch.pos_x, in_ch.pos_y, in_ch.pos_z});
      if (out_ch.valid && out_ch.ready) begin
        if (expected_matches.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result idx=%0d found=%0b last=%0b",
                     out_ch.match_index, out_ch.found, out_ch.last);
        end else begin
          match_t e;
          e = expected_matches.pop_front();
          if (out_ch.match_index !== e.idx || out_ch.found !== e.found ||
              out_ch.last !== e.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp idx=%0d found=%0b last=%0b, got %0d %0b %0b",
                       e.idx, e.found, e.last,
                       out_ch.match_index, out_ch.found, out_ch.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("** spatial_sort_radius_query_top: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg.index <= idx;
    cfg.data <= val;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_NX: nrm_x = val[15:0];
      REG_NY: nrm_y = val[15:0];
      REG_NZ: nrm_z = val[15:0];
      default: radius = val;
    endcase
    cfg.valid <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                            logic [23:0] r);
    write_reg(REG_NX, {8'd0, nx});
    write_reg(REG_NY, {8'd0, ny});
    write_reg(REG_NZ, {8'd0, nz});
    write_reg(REG_RAD, r);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_ch.valid || expected_matches.size() != 0)
      @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  function automatic logic [23:0] near(int c, int s);
    return 24'(c + int'($urandom_range(0, 2 * s)) - s);
  endfunction

  // clustered loads and queries after a clear, a few random full-range items and clears mixed in
  task automatic cluster_phase(int n_items, int s);
    int cx, cy, cz, k;
    cmd_item_t it;
    cx = int'($urandom_range(0, 1 << 22)) - (1 << 21);
    cy = int'($urandom_range(0, 1 << 22)) - (1 << 21);
    cz = int'($urandom_range(0, 1 << 22)) - (1 << 21);
    add_item('{CMD_CLEAR, 24'd0, 24'd0, 24'd0});
    for (int i = 0; i < n_items; i++) begin
      k = $urandom_range(0, 99);
      if (k < 8)
        it = '{2'($urandom), 24'($urandom), 24'($urandom), 24'($urandom)};
      else if (k < 10)
        it = '{CMD_CLEAR, 24'($urandom), 24'($urandom), 24'($urandom)};
      else if (k < 55)
        it = '{CMD_LOAD, near(cx, s), near(cy, s), near(cz, s)};
      else
        it = '{CMD_QUERY, near(cx, s), near(cy, s), near(cz, s)};
      add_item(it);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_stored = 0;
    nrm_x = 16'sd25782;
    nrm_y = 16'sd10383;
    nrm_z = 16'sd17353;
    radius = 24'd1;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_LOAD;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_NX;
    cfg.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store, extremes, unused code, exact hits at radius 1
    add_item('{CMD_QUERY, 24'd0, 24'd0, 24'd0});
    add_item('{CMD_LOAD, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
    add_item('{CMD_LOAD, 24'h800000, 24'h800000, 24'h800000});
    add_item('{CMD_LOAD, 24'd0, 24'd0, 24'd0});
    add_item('{CMD_LOAD, 24'd0, 24'd0, 24'd0});
    add_item('{2'd3, 24'h7FFFFF, 24'h800000, 24'h555555});
    add_item('{CMD_QUERY, 24'd0, 24'd0, 24'd0});
    add_item('{CMD_QUERY, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
    add_item('{CMD_QUERY, 24'h800000, 24'h800000, 24'h800000});
    add_item('{CMD_QUERY, 24'd1, 24'd0, 24'd0});
    add_item('{CMD_CLEAR, 24'd0, 24'd0, 24'd0});
    add_item('{CMD_QUERY, 24'd0, 24'd0, 24'd0});
    drain();

    // widest radius, full store plus loads past capacity
    set_config(16'h7FFF, 16'h7FFF, 16'h7FFF, 24'hFFFFFF);
    for (int i = 0; i < 68; i++)
      add_item('{CMD_LOAD, near(0, 1 << 20), near(0, 1 << 20), near(0, 1 << 20)});
    add_item('{CMD_QUERY, 24'd0, 24'd0, 24'd0});
    add_item('{CMD_QUERY, 24'h7FFFFF, 24'h800000, 24'd0});
    drain();

    // zero radius never matches
    set_config(16'h8000, 16'h8000, 16'h8000, 24'd0);
    cluster_phase(16, 64);
    drain();

    send_idle_pct = 78;
    recv_stall_pct = 0;
    set_config(16'($urandom), 16'($urandom), 16'($urandom), 24'd3000);
    cluster_phase(40, 2000);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 78;
    set_config(16'h8000, 16'h7FFF, 16'h0000, 24'($urandom_range(1000, 60000)));
    cluster_phase(40, 20000);
    drain();

    send_idle_pct = 27;
    recv_stall_pct = 27;
    set_config(16'sd25782, 16'sd10383, 16'sd17353, 24'd4096);
    cluster_phase(40, 3000);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(16'($urandom), 16'($urandom), 16'($urandom), 24'd800);
    cluster_phase(30, 600);
    drain();

    if (errors == 0)
      $display("** spatial_sort_radius_query_top: PASSED **");
    else
      $display("** spatial_sort_radius_query_top: FAILED **");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/ssrq_pkg.sv
rtl/ssrq_if.sv
rtl/ssrq_cell.sv
rtl/spatial_sort_radius_query_top.sv
tb/spatial_sort_radius_query_top_tb.sv
